// File: rtl/bmh_pkg.sv
// Shared types and constants of the binary max-heap.
`timescale 1ns / 1ps

package bmh_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 1024;
    localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_LOAD  = 2'd2,
        OP_BUILD = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

// File: rtl/bmh_in_if.sv
// Command channel of the binary max-heap: valid, ready, opcode and value.
`timescale 1ns / 1ps

interface bmh_in_if;

    logic                                valid;
    logic                                ready;
    bmh_pkg::opcode_t                    opcode;
    logic signed [bmh_pkg::DATA_W-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);

endinterface

// File: rtl/bmh_out_if.sv
// Result channel of the binary max-heap: valid, ready and the result fields.
`timescale 1ns / 1ps

interface bmh_out_if #(
    parameter int CNT_W = bmh_pkg::CNT_W_DEF
);

    logic                                valid;
    logic                                ready;
    bmh_pkg::status_t                    status;
    logic signed [bmh_pkg::DATA_W-1:0]   top_value;
    logic signed [bmh_pkg::DATA_W-1:0]   removed_value;
    logic [CNT_W-1:0]                    count;
    logic                                is_empty;

    modport source (output valid, output status, output top_value, output removed_value,
                    output count, output is_empty, input ready);
    modport sink   (input valid, input status, input top_value, input removed_value,
                    input count, input is_empty, output ready);

endinterface

// File: rtl/bmh_ram.sv
// Heap entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module bmh_ram #(
    parameter int DEPTH  = bmh_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(bmh_pkg::CAPACITY_DEF)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [bmh_pkg::DATA_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [bmh_pkg::DATA_W-1:0]  rdata
);

    logic [bmh_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/binary_max_heap.sv
// Binary max-heap priority queue: top level with the sift sequencer.
`timescale 1ns / 1ps

// A max-heap of signed 32-bit values held in one memory of CAPACITY entries, driven by one
// sequencer and one signed comparator that all sift steps share. The block takes one command
// item at a time and returns one result item for it. Load stores the value behind the last
// entry; push lets the value climb level by level until its parent is not smaller or it
// reaches the root; pop moves the last entry to the root and lets it sink level by level.
// Build sifts each non-leaf entry down in turn and does nothing on fewer than two entries.
// Every parent or child is fetched one after the other through the single memory read port.
// The root is mirrored in a register, so no memory read is spent on the result. The next
// command is taken while the previous result waits in the output register.
module binary_max_heap #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bmh_in_if.sink      cmd,
    bmh_out_if.source   res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CHD_W = IDX_W + 2;
    localparam int DW    = bmh_pkg::DATA_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_UP_RD  = 9'b000000010,
        S_UP_CMP = 9'b000000100,
        S_POP_LD = 9'b000001000,
        S_BLD_LD = 9'b000010000,
        S_DN_L   = 9'b000100000,
        S_DN_R   = 9'b001000000,
        S_DN_CMP = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [IDX_W-1:0]     bi_reg, bi_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [DW-1:0]        mv_reg, mv_next;
    logic [DW-1:0]        best_val_reg, best_val_next;
    logic [DW-1:0]        removed_reg, removed_next;
    logic [DW-1:0]        root_reg;
    logic                 r_ok_reg, r_ok_next;
    logic                 build_reg, build_next;
    bmh_pkg::status_t     status_reg, status_next;

    logic                 res_valid_reg;
    bmh_pkg::status_t     res_status_reg;
    logic [DW-1:0]        res_top_reg;
    logic [DW-1:0]        res_removed_reg;
    logic [CNT_W-1:0]     res_count_reg;
    logic                 load_out;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [DW-1:0]        ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [DW-1:0]        ram_rdata;

    logic [DW-1:0]        cmp_a;
    logic [DW-1:0]        cmp_b;
    logic                 a_gt_b;
    logic [IDX_W-1:0]     parent_idx;
    logic [CHD_W-1:0]     left_idx;
    logic [CHD_W-1:0]     right_idx;
    logic [CHD_W-1:0]     n_ext;
    logic [IDX_W-1:0]     sel_idx;
    logic [DW-1:0]        sel_val;
    logic                 full;

    bmh_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The shared comparator: the moving value against its parent on the way up, and a fetched
    // child against the moving value or the best so far on the way down.
    assign cmp_a  = (state_reg == S_UP_CMP) ? mv_reg : ram_rdata;
    assign cmp_b  = (state_reg == S_UP_CMP) ? ram_rdata :
                    ((state_reg == S_DN_CMP) ? best_val_reg : mv_reg);
    assign a_gt_b = $signed(cmp_a) > $signed(cmp_b);

    assign parent_idx = (i_reg - 1'b1) >> 1;
    assign left_idx   = {1'b0, i_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign n_ext      = CHD_W'(count_reg);
    assign full       = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        if (r_ok_reg && a_gt_b)
        begin
            sel_idx = right_idx[IDX_W-1:0];
            sel_val = ram_rdata;
        end
        else
        begin
            sel_idx = best_idx_reg;
            sel_val = best_val_reg;
        end
    end

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        bi_next       = bi_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        mv_next       = mv_reg;
        removed_next  = removed_reg;
        r_ok_next     = r_ok_reg;
        build_next    = build_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;
        load_out      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    status_next  = bmh_pkg::ST_OK;
                    removed_next = '0;
                    build_next   = 1'b0;
                    state_next   = S_DONE;
                    case (cmd.opcode)
                        bmh_pkg::OP_PUSH, bmh_pkg::OP_LOAD:
                        begin
                            if (full)
                            begin
                                status_next = bmh_pkg::ST_FULL;
                            end
                            else if (cmd.opcode == bmh_pkg::OP_LOAD)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = IDX_W'(count_reg);
                                ram_wdata  = cmd.value;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                mv_next    = cmd.value;
                                i_next     = IDX_W'(count_reg);
                                count_next = count_reg + 1'b1;
                                state_next = S_UP_RD;
                            end
                        end
                        bmh_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bmh_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                removed_next = root_reg;
                                ram_raddr    = IDX_W'(count_reg - 1'b1);
                                state_next   = S_POP_LD;
                            end
                        end
                        default:
                        begin
                            if (count_reg >= CNT_W'(2))
                            begin
                                bi_next    = IDX_W'((count_reg - CNT_W'(2)) >> 1);
                                i_next     = IDX_W'((count_reg - CNT_W'(2)) >> 1);
                                ram_raddr  = IDX_W'((count_reg - CNT_W'(2)) >> 1);
                                build_next = 1'b1;
                                state_next = S_BLD_LD;
                            end
                        end
                    endcase
                end
            end

            S_UP_RD:
            begin
                if (i_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = mv_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                if (a_gt_b)
                begin
                    ram_wdata  = ram_rdata;
                    i_next     = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    ram_wdata  = mv_reg;
                    state_next = S_DONE;
                end
            end

            S_POP_LD:
            begin
                mv_next    = ram_rdata;
                count_next = count_reg - 1'b1;
                i_next     = '0;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_L;
                end
            end

            S_BLD_LD:
            begin
                mv_next    = ram_rdata;
                state_next = S_DN_L;
            end

            S_DN_L:
            begin
                if (left_idx >= n_ext)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = i_reg;
                    ram_wdata = mv_reg;
                    if (build_reg && (bi_reg != '0))
                    begin
                        bi_next    = bi_reg - 1'b1;
                        i_next     = bi_reg - 1'b1;
                        ram_raddr  = bi_reg - 1'b1;
                        state_next = S_BLD_LD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ram_raddr  = left_idx[IDX_W-1:0];
                    r_ok_next  = (right_idx < n_ext);
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                if (a_gt_b)
                begin
                    best_val_next = ram_rdata;
                    best_idx_next = left_idx[IDX_W-1:0];
                end
                else
                begin
                    best_val_next = mv_reg;
                    best_idx_next = i_reg;
                end
                ram_raddr  = right_idx[IDX_W-1:0];
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                if (sel_idx == i_reg)
                begin
                    ram_wdata = mv_reg;
                    if (build_reg && (bi_reg != '0))
                    begin
                        bi_next    = bi_reg - 1'b1;
                        i_next     = bi_reg - 1'b1;
                        ram_raddr  = bi_reg - 1'b1;
                        state_next = S_BLD_LD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ram_wdata  = sel_val;
                    i_next     = sel_idx;
                    state_next = S_DN_L;
                end
            end

            S_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        bi_reg       <= bi_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        mv_reg       <= mv_next;
        removed_reg  <= removed_next;
        r_ok_reg     <= r_ok_next;
        build_reg    <= build_next;
        status_reg   <= status_next;
        if (ram_we && (ram_waddr == '0))
        begin
            root_reg <= ram_wdata;
        end
        if (load_out)
        begin
            res_status_reg  <= status_reg;
            res_top_reg     <= (count_reg != '0) ? root_reg : '0;
            res_removed_reg <= removed_reg;
            res_count_reg   <= count_reg;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = res_status_reg;
    assign res.top_value     = res_top_reg;
    assign res.removed_value = res_removed_reg;
    assign res.count         = res_count_reg;
    assign res.is_empty      = (res_count_reg == '0);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds the capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= count_reg))
        else $error("memory write beyond the stored entries");
`endif

endmodule

// File: dv/binary_max_heap_checker.sv
// Checker for the binary max-heap: predicts each result item and compares it with the block.
`timescale 1ns / 1ps

module binary_max_heap_checker #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bmh_in_if    cmd,
    bmh_out_if   res,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        bmh_pkg::status_t                   status;
        logic signed [bmh_pkg::DATA_W-1:0]  top_value;
        logic signed [bmh_pkg::DATA_W-1:0]  removed_value;
        logic [bmh_pkg::CNT_W_DEF-1:0]      count;
        logic                               is_empty;
    } heap_result_t;

    logic signed [bmh_pkg::DATA_W-1:0] heap_mem [CAPACITY];
    int unsigned                       heap_fill = 0;
    heap_result_t                      result_fifo [$];
    int                                fails = 0;
    int                                waiting = 0;
    int                                seen = 0;

    assign fail_count = fails;
    assign pending    = waiting;
    assign checked    = seen;

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic signed [bmh_pkg::DATA_W-1:0] t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic void bubble_up(int unsigned start);
        int unsigned i;
        int unsigned p;
        bit          done;
        i    = start;
        done = 1'b0;
        while (!done && i > 0)
        begin
            p = (i - 1) / 2;
            if (heap_mem[i] > heap_mem[p])
            begin
                swap_slots(i, p);
                i = p;
            end
            else
            begin
                done = 1'b1;
            end
        end
    endfunction

    function automatic void bubble_down(int unsigned start);
        int unsigned i;
        int unsigned lc;
        int unsigned rc;
        int unsigned best;
        bit          done;
        i    = start;
        done = 1'b0;
        while (!done && i < heap_fill)
        begin
            lc   = 2 * i + 1;
            rc   = 2 * i + 2;
            best = i;
            if (lc < heap_fill && heap_mem[lc] > heap_mem[best])
                best = lc;
            if (rc < heap_fill && heap_mem[rc] > heap_mem[best])
                best = rc;
            if (best == i)
            begin
                done = 1'b1;
            end
            else
            begin
                swap_slots(i, best);
                i = best;
            end
        end
    endfunction

    function automatic heap_result_t apply_cmd(bmh_pkg::opcode_t op,
                                               logic signed [bmh_pkg::DATA_W-1:0] v);
        heap_result_t r;
        int unsigned  k;
        r.status        = bmh_pkg::ST_OK;
        r.removed_value = '0;
        case (op)
            bmh_pkg::OP_PUSH, bmh_pkg::OP_LOAD:
            begin
                if (heap_fill >= CAPACITY)
                begin
                    r.status = bmh_pkg::ST_FULL;
                end
                else
                begin
                    heap_mem[heap_fill] = v;
                    heap_fill++;
                    if (op == bmh_pkg::OP_PUSH)
                        bubble_up(heap_fill - 1);
                end
            end
            bmh_pkg::OP_POP:
            begin
                if (heap_fill == 0)
                begin
                    r.status = bmh_pkg::ST_EMPTY;
                end
                else
                begin
                    r.removed_value = heap_mem[0];
                    swap_slots(0, heap_fill - 1);
                    heap_fill--;
                    bubble_down(0);
                end
            end
            default:
            begin
                if (heap_fill >= 2)
                begin
                    for (k = heap_fill / 2; k > 0; k--)
                        bubble_down(k - 1);
                end
            end
        endcase
        r.top_value = (heap_fill != 0) ? heap_mem[0] : '0;
        r.count     = heap_fill[bmh_pkg::CNT_W_DEF-1:0];
        r.is_empty  = (heap_fill == 0);
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        heap_result_t got;
        heap_result_t want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                got.status        = res.status;
                got.top_value     = res.top_value;
                got.removed_value = res.removed_value;
                got.count         = res.count;
                got.is_empty      = res.is_empty;
                seen++;
                if (result_fifo.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] Result item with none expected: status %0d top %0d",
                                 $realtime, got.status, got.top_value);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("[%0t] Mismatch: expected status %0d top %0d removed %0d",
                                     $realtime, want.status, want.top_value,
                                     want.removed_value);
                            $display("    count %0d empty %0b; got status %0d top %0d",
                                     want.count, want.is_empty, got.status, got.top_value);
                            $display("    removed %0d count %0d empty %0b",
                                     got.removed_value, got.count, got.is_empty);
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                result_fifo.insert(result_fifo.size(), apply_cmd(cmd.opcode, cmd.value));
            waiting = result_fifo.size();
        end
    end

endmodule

// File: dv/binary_max_heap_tb.sv
// Testbench top for the binary max-heap: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module binary_max_heap_tb;

    localparam int CAP   = bmh_pkg::CAPACITY_DEF;
    localparam int ITEMS = 1800;

    logic clk;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;
    bit   idle_on = 1'b1;
    int   stall_left = 0;

    int fail_count;
    int pending;
    int checked;

    int sent = 0;
    int depth = 0;
    int peak = 0;
    int rejected = 0;
    int op_seen [4] = '{0, 0, 0, 0};

    bmh_in_if  cmd_if ();
    bmh_out_if res_if ();

    assign res_if.ready = sink_ready;

    binary_max_heap #(.CAPACITY(CAP)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    binary_max_heap_checker #(.CAPACITY(CAP)) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_if),
        .res        (res_if),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end
        else if (rst_n && idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= rst_n;
        end
    end

    function automatic logic signed [bmh_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            4, 5:    return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(bmh_pkg::opcode_t op, logic signed [bmh_pkg::DATA_W-1:0] v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.opcode <= op;
        cmd_if.value  <= v;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sent++;
        op_seen[op]++;
        if (op == bmh_pkg::OP_PUSH || op == bmh_pkg::OP_LOAD)
        begin
            if (depth < CAP)
                depth++;
            else
                rejected++;
        end
        else if (op == bmh_pkg::OP_POP)
        begin
            if (depth > 0)
                depth--;
            else
                rejected++;
        end
        if (depth > peak)
            peak = depth;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int kind;
        int len;
        cmd_if.valid  = 1'b0;
        cmd_if.opcode = bmh_pkg::OP_PUSH;
        cmd_if.value  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_cmd(bmh_pkg::OP_POP, 32'h1234_5678);
        send_cmd(bmh_pkg::OP_BUILD, '0);
        send_cmd(bmh_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_cmd(bmh_pkg::OP_BUILD, '1);
        send_cmd(bmh_pkg::OP_PUSH, 32'h8000_0000);
        send_cmd(bmh_pkg::OP_PUSH, 32'h0000_0000);
        send_cmd(bmh_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_cmd(bmh_pkg::OP_PUSH, 32'h0000_0001);
        send_cmd(bmh_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_cmd(bmh_pkg::OP_POP, '0);
        send_cmd(bmh_pkg::OP_POP, '0);
        send_cmd(bmh_pkg::OP_LOAD, 32'h8000_0000);
        send_cmd(bmh_pkg::OP_LOAD, 32'h7FFF_FFFF);
        send_cmd(bmh_pkg::OP_LOAD, 32'h0000_0005);
        send_cmd(bmh_pkg::OP_BUILD, '0);
        repeat (8) send_cmd(bmh_pkg::OP_POP, '0);
        wait_drained();

        while (sent < ITEMS - CAP - 80)
        begin
            idle_on <= ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 4);
            len  = $urandom_range(1, 40);
            case (kind)
                0:
                begin
                    repeat (len) send_cmd(bmh_pkg::OP_PUSH, pick_value());
                    repeat (len + $urandom_range(0, 2)) send_cmd(bmh_pkg::OP_POP, pick_value());
                end
                1:
                begin
                    repeat (len) send_cmd(bmh_pkg::OP_LOAD, pick_value());
                    send_cmd(bmh_pkg::OP_BUILD, pick_value());
                    repeat ($urandom_range(1, len)) send_cmd(bmh_pkg::OP_POP, pick_value());
                end
                2:
                begin
                    repeat (len)
                        send_cmd(bmh_pkg::opcode_t'($urandom_range(0, 3)), pick_value());
                end
                3:
                begin
                    repeat (2 * len)
                        send_cmd(($urandom_range(0, 1) != 0) ? bmh_pkg::OP_PUSH : bmh_pkg::OP_POP,
                                 pick_value());
                end
                default:
                begin
                    repeat (depth + 1) send_cmd(bmh_pkg::OP_POP, pick_value());
                end
            endcase
            if (depth > 200)
                repeat (depth - $urandom_range(0, 20)) send_cmd(bmh_pkg::OP_POP, pick_value());
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        // The closing part runs with no idling: fill the heap, hit the full case, rebuild, then pop and push.
        idle_on <= 1'b0;
        while (depth < CAP)
            send_cmd(($urandom_range(0, 3) == 0) ? bmh_pkg::OP_LOAD : bmh_pkg::OP_PUSH,
                     pick_value());
        repeat (2) send_cmd(bmh_pkg::OP_PUSH, pick_value());
        repeat (2) send_cmd(bmh_pkg::OP_LOAD, pick_value());
        send_cmd(bmh_pkg::OP_BUILD, pick_value());
        repeat (12) send_cmd(bmh_pkg::OP_POP, pick_value());
        repeat (12) send_cmd(bmh_pkg::OP_PUSH, pick_value());
        send_cmd(bmh_pkg::OP_PUSH, pick_value());
        repeat (6) send_cmd(bmh_pkg::OP_POP, pick_value());

        wait_drained();
        repeat (40) @(negedge clk);

        $display("Sent %0d commands: %0d push, %0d pop, %0d load, %0d build;",
                 sent, op_seen[bmh_pkg::OP_PUSH], op_seen[bmh_pkg::OP_POP],
                 op_seen[bmh_pkg::OP_LOAD], op_seen[bmh_pkg::OP_BUILD]);
        $display("%0d hit empty or full; heap held up to %0d of %0d entries; %0d compared, %0d owed.",
                 rejected, peak, CAP, checked, pending);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results still owed.", pending);
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/bmh_pkg.sv
rtl/bmh_in_if.sv
rtl/bmh_out_if.sv
rtl/bmh_ram.sv
rtl/binary_max_heap.sv
dv/binary_max_heap_checker.sv
dv/binary_max_heap_tb.sv
